>>> design/ilp_pkg.sv
package ilp_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned HalfWidth  = 64;
   localparam int unsigned AccWidth   = 2 * HalfWidth;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned KindWidth  = 2;

   // parser phases
   localparam logic [PhaseWidth-1:0] PH_FIRST  = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_ZERO   = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_DIGITS = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_DONE   = 3'd3;

   // radix codes as reported in the result
   localparam logic [KindWidth-1:0] KIND_DEC = 2'd0;
   localparam logic [KindWidth-1:0] KIND_HEX = 2'd1;
   localparam logic [KindWidth-1:0] KIND_OCT = 2'd2;

   // characters of interest
   localparam logic [CharWidth-1:0] CH_NUL   = 8'h00;
   localparam logic [CharWidth-1:0] CH_MINUS = 8'h2d;
   localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CH_ONE   = 8'h31;
   localparam logic [CharWidth-1:0] CH_SEVEN = 8'h37;
   localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
   localparam logic [CharWidth-1:0] CH_LO_A  = 8'h61;
   localparam logic [CharWidth-1:0] CH_LO_F  = 8'h66;
   localparam logic [CharWidth-1:0] CH_LO_X  = 8'h78;
   localparam logic [CharWidth-1:0] CH_UP_A  = 8'h41;
   localparam logic [CharWidth-1:0] CH_UP_F  = 8'h46;

   // raw result handed from the parser to the sign stage
   typedef struct packed {
      logic [AccWidth-1:0]  acc;
      logic                 negative;
      logic                 ok;
      logic [KindWidth-1:0] kind;
   } raw_result_type;

endpackage

>>> design/ilp_core.sv
module ilp_core
   import ilp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CharWidth-1:0] req_tdata,
   input  logic                 req_tlast,
   output logic                 res_valid,
   output raw_result_type       res,
   input  logic                 res_ready
);

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic                  negative;
      logic [AccWidth-1:0]   acc;
      logic                  seen;
      logic [KindWidth-1:0]  kind;
   } parse_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   localparam parse_type PARSE_RESET = '{
      phase: PH_FIRST, negative: 1'b0, acc: '0, seen: 1'b0, kind: KIND_DEC};

   function automatic digit_type digit_decode(logic [CharWidth-1:0] ch,
                                              logic [KindWidth-1:0] kind);
      digit_type d;
      logic [CharWidth-1:0] dec_off;
      logic [CharWidth-1:0] lo_off;
      logic [CharWidth-1:0] up_off;
      dec_off = ch - CH_ZERO;
      lo_off  = ch - CH_LO_A + 8'd10;
      up_off  = ch - CH_UP_A + 8'd10;
      d.valid = 1'b0;
      d.value = dec_off[3:0];
      if (kind == KIND_HEX) begin
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            d.valid = 1'b1;
         end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
            d.valid = 1'b1;
            d.value = lo_off[3:0];
         end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
            d.valid = 1'b1;
            d.value = up_off[3:0];
         end
      end else if (kind == KIND_OCT) begin
         d.valid = (ch >= CH_ZERO && ch <= CH_SEVEN);
      end else begin
         d.valid = (ch >= CH_ZERO && ch <= CH_NINE);
      end
      return d;
   endfunction

   function automatic parse_type parse_char(parse_type s, logic [CharWidth-1:0] ch);
      parse_type n;
      digit_type d;
      logic [AccWidth-1:0] scaled;
      n = s;
      d = digit_decode(ch, s.kind);
      // shift-add scaling of the accumulator by the radix
      if (s.kind == KIND_HEX) begin
         scaled = s.acc << 4;
      end else if (s.kind == KIND_OCT) begin
         scaled = s.acc << 3;
      end else begin
         scaled = (s.acc << 3) + (s.acc << 1);
      end
      unique case (s.phase)
         PH_FIRST: begin
            n.acc  = '0;
            n.seen = 1'b0;
            n.kind = KIND_DEC;
            if (ch == CH_MINUS) begin
               n.negative = 1'b1;
               n.phase    = PH_DIGITS;
            end else if (ch == CH_ZERO) begin
               n.phase = PH_ZERO;
            end else if (ch >= CH_ONE && ch <= CH_NINE) begin
               n.phase = PH_DIGITS;
               n.acc   = AccWidth'(ch - CH_ZERO);
               n.seen  = 1'b1;
            end else begin
               n.phase = PH_DONE;
            end
         end
         PH_ZERO: begin
            n.acc = '0;
            if (ch == CH_NUL) begin
               // lone zero
               n.phase = PH_DONE;
               n.seen  = 1'b1;
               n.kind  = KIND_DEC;
            end else if (ch == CH_LO_X) begin
               n.phase = PH_DIGITS;
               n.seen  = 1'b0;
               n.kind  = KIND_HEX;
            end else begin
               // octal run starts at this character
               n.kind = KIND_OCT;
               if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
                  n.phase = PH_DIGITS;
                  n.acc   = AccWidth'(ch - CH_ZERO);
                  n.seen  = 1'b1;
               end else begin
                  n.phase = PH_DONE;
                  n.seen  = 1'b0;
               end
            end
         end
         PH_DIGITS: begin
            if (d.valid) begin
               n.acc  = scaled + AccWidth'(d.value);
               n.seen = 1'b1;
            end else begin
               n.phase = PH_DONE;
            end
         end
         default: begin
         end
      endcase
      return n;
   endfunction

   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] in_char_ff;
   logic                 in_last_ff;
   parse_type            state_ff, state_in;
   logic                 res_valid_ff, res_valid_in;
   raw_result_type       res_ff, res_in;
   parse_type            step;
   parse_type            fin;
   logic                 fire;
   logic                 fin_ok;

   assign fire       = in_valid_ff && (!in_last_ff || !res_valid_ff || res_ready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      step   = parse_char(state_ff, in_char_ff);
      // end of string acts as a terminator
      fin    = parse_char(step, CH_NUL);
      fin_ok = (fin.phase == PH_DONE) && fin.seen;

      in_valid_in = req_tready ? req_tvalid : in_valid_ff;

      state_in = state_ff;
      if (fire) begin
         state_in = in_last_ff ? PARSE_RESET : step;
      end

      res_valid_in = res_valid_ff;
      if (fire && in_last_ff) begin
         res_valid_in = 1'b1;
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end

      res_in.acc      = fin_ok ? fin.acc : '0;
      res_in.negative = fin_ok && fin.negative;
      res_in.ok       = fin_ok;
      res_in.kind     = fin.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         state_ff     <= PARSE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && in_last_ff) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

>>> design/ilp_sign.sv
module ilp_sign
   import ilp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  raw_result_type        res,
   output logic                  res_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [AccWidth-1:0]   rsp_value,
   output logic                  rsp_ok,
   output logic [KindWidth-1:0]  rsp_kind
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AccWidth-1:0]  value_ff, value_in;
   logic                 ok_ff;
   logic [KindWidth-1:0] kind_ff;
   logic                 take;

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign take      = res_valid && res_ready;

   always_comb begin
      // two's complement negation for a leading minus
      value_in     = res.negative ? (~res.acc + AccWidth'(1)) : res.acc;
      rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= value_in;
         ok_ff    <= res.ok;
         kind_ff  <= res.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_ok     = ok_ff;
   assign rsp_kind   = kind_ff;

endmodule

>>> design/int128_literal_parser.sv
// a result passes from the input register through the raw result register to the output register
// throughput: one item per cycle, set by the parser step, unless the input is held
// a stalled result holds the input only when the last item of a string finds
// both result registers full; other items keep flowing into the parser
// reset: synchronous, active high; clears all valids and returns the parser to
// the first-character phase
module int128_literal_parser
   import ilp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input items: one string character each
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] character
   input  logic         req_tlast,   // end_of_string
   // result items: one per string
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] value_high, [127:64] value_low
   output logic [2:0]   rsp_tuser    // [0] ok, [2:1] radix_kind
);

   raw_result_type       res;
   logic                 res_valid;
   logic                 res_ready;
   logic [AccWidth-1:0]  value;
   logic                 ok;
   logic [KindWidth-1:0] kind;

   // input register, parser state and raw result register
   ilp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready)
   );

   // sign fix-up and output register
   ilp_sign u_sign (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (value),
      .rsp_ok     (ok),
      .rsp_kind   (kind)
   );

   // value_high sits in the low half of the data word
   assign rsp_tdata = {value[HalfWidth-1:0], value[AccWidth-1:HalfWidth]};
   assign rsp_tuser = {kind, ok};

endmodule

>>> design/ilp_checker.sv
module ilp_checker
   import ilp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // an error result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 128'd0)
      else $error("error result with nonzero value");

   // radix code stays within its three meanings
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] != 2'd3)
      else $error("bad radix code");

endmodule

bind int128_literal_parser ilp_checker u_ilp_checker (.*);

>>> sim/int128_literal_parser_tb.sv
`timescale 1ns / 1ps

module int128_literal_parser_tb;
   import ilp_pkg::*;

   typedef struct packed {
      logic [HalfWidth-1:0] value_high;
      logic [HalfWidth-1:0] value_low;
      logic                 ok;
      logic [KindWidth-1:0] radix_kind;
   } literal_result_type;

   // tracks the parser state per string and holds the results still owed
   class literal_checker;
      logic [PhaseWidth-1:0] parse_phase;
      bit                    minus_seen;
      logic [AccWidth-1:0]   accum;
      bit                    has_digit;
      logic [KindWidth-1:0]  radix;
      literal_result_type    expected_values[$];
      int                    errors;
      int                    results_seen;

      function new();
         errors = 0;
         results_seen = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         parse_phase = PH_FIRST;
         minus_seen = 0;
         accum = '0;
         has_digit = 0;
         radix = KIND_DEC;
      endfunction

      function void open_run(logic [KindWidth-1:0] kind);
         radix = kind;
         parse_phase = PH_DIGITS;
         has_digit = 0;
         accum = '0;
      endfunction

      // digit value in the current radix, -1 when the char is not a digit
      function int digit_of(logic [CharWidth-1:0] ch, logic [KindWidth-1:0] kind);
         if (kind == KIND_HEX) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
            if (ch >= CH_LO_A && ch <= CH_LO_F) return int'(ch - CH_LO_A) + 10;
            if (ch >= CH_UP_A && ch <= CH_UP_F) return int'(ch - CH_UP_A) + 10;
            return -1;
         end
         if (kind == KIND_OCT) begin
            if (ch >= CH_ZERO && ch <= CH_SEVEN) return int'(ch - CH_ZERO);
            return -1;
         end
         if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
         return -1;
      endfunction

      // wraps modulo 2^128
      function void add_digit(int d);
         case (radix)
            KIND_HEX: accum = (accum << 4) + AccWidth'(d);
            KIND_OCT: accum = (accum << 3) + AccWidth'(d);
            default:  accum = accum * AccWidth'(10) + AccWidth'(d);
         endcase
         has_digit = 1;
      endfunction

      function void take_char(logic [CharWidth-1:0] ch);
         int d;
         case (parse_phase)
            PH_FIRST: begin
               if (ch == CH_MINUS) begin
                  minus_seen = 1;
                  open_run(KIND_DEC);
               end else if (ch == CH_ZERO) begin
                  parse_phase = PH_ZERO;
               end else if (ch >= CH_ONE && ch <= CH_NINE) begin
                  open_run(KIND_DEC);
                  add_digit(int'(ch - CH_ZERO));
               end else begin
                  parse_phase = PH_DONE;
                  has_digit = 0;
                  radix = KIND_DEC;
               end
            end
            PH_ZERO: begin
               if (ch == CH_NUL) begin
                  // lone zero
                  parse_phase = PH_DONE;
                  has_digit = 1;
                  radix = KIND_DEC;
               end else if (ch == CH_LO_X) begin
                  open_run(KIND_HEX);
               end else begin
                  // octal starts at the char after the leading zero
                  open_run(KIND_OCT);
                  d = digit_of(ch, KIND_OCT);
                  if (d >= 0) add_digit(d);
                  else parse_phase = PH_DONE;
               end
            end
            PH_DIGITS: begin
               d = digit_of(ch, radix);
               if (d >= 0) add_digit(d);
               else parse_phase = PH_DONE;
            end
            default: ;
         endcase
      endfunction

      function void note_char(logic [CharWidth-1:0] ch, bit last);
         literal_result_type want;
         logic [AccWidth-1:0] value;
         take_char(ch);
         if (!last) return;
         // end of string acts as a terminator
         take_char(CH_NUL);
         want.ok = (parse_phase == PH_DONE) && has_digit;
         value = '0;
         if (want.ok) value = minus_seen ? -accum : accum;
         want.value_high = value[AccWidth-1:HalfWidth];
         want.value_low = value[HalfWidth-1:0];
         want.radix_kind = radix;
         expected_values.push_back(want);
         clear_parse();
      endfunction

      function void compare_field(string field, logic [HalfWidth-1:0] want,
                                  logic [HalfWidth-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [127:0] data, logic [2:0] user);
         literal_result_type want;
         results_seen++;
         if (expected_values.size() == 0) begin
            $error("result with nothing expected: data %0h user %0h", data, user);
            errors++;
            return;
         end
         want = expected_values.pop_front();
         compare_field("value_high", want.value_high, data[63:0]);
         compare_field("value_low", want.value_low, data[127:64]);
         compare_field("ok", HalfWidth'(want.ok), HalfWidth'(user[0]));
         compare_field("radix_kind", HalfWidth'(want.radix_kind), HalfWidth'(user[2:1]));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   literal_checker checker_h;
   logic [CharWidth-1:0] text[$];
   int  chars_sent;
   int  req_gap;
   int  req_burst;
   int  rsp_burst;
   bit  holding_off;

   int128_literal_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // mostly random gaps, now and then a run of back-to-back items
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // valid stays high into the next item when its gap is zero
   task send_item(input logic [CharWidth-1:0] ch, input bit last);
      repeat (req_gap) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= ch;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      checker_h.note_char(ch, last);
      chars_sent++;
      req_gap = holding_off ? 0 : draw_gap(req_burst);
      if (req_gap != 0) req_tvalid <= 0;
   endtask

   task send_text();
      for (int i = 0; i < text.size(); i++)
         send_item(text[i], i == text.size() - 1);
   endtask

   task send_str(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_text();
   endtask

   function automatic logic [CharWidth-1:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return CH_ZERO + CharWidth'(v);
      return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CharWidth'(v - 10);
   endfunction

   // mostly well-formed literals with random digits, some broken or noise
   task make_random_text();
      int mode;
      int n;
      text.delete();
      mode = $urandom_range(0, 9);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 12);
      case (mode)
         0: begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(CharWidth'($urandom_range(0, 255)));
         end
         1: begin
            // prefix with no digits, maybe followed by a stray byte
            case ($urandom_range(0, 3))
               0: text.push_back(CH_MINUS);
               1: begin text.push_back(CH_ZERO); text.push_back(CH_LO_X); end
               2: begin text.push_back(CH_ZERO); text.push_back(CH_NINE); end
               default: begin text.push_back(CH_ZERO); text.push_back(8'h58); end
            endcase
            if ($urandom_range(0, 1)) text.push_back(CharWidth'($urandom_range(0, 255)));
         end
         2, 3: begin
            text.push_back(CH_ONE + CharWidth'($urandom_range(0, 8)));
            repeat (n) text.push_back(CH_ZERO + CharWidth'($urandom_range(0, 9)));
         end
         4: begin
            text.push_back(CH_MINUS);
            repeat (n + 1) text.push_back(CH_ZERO + CharWidth'($urandom_range(0, 9)));
         end
         5, 6: begin
            text.push_back(CH_ZERO);
            text.push_back(CH_LO_X);
            repeat (n + 1) text.push_back(hex_char());
         end
         7, 8: begin
            text.push_back(CH_ZERO);
            repeat (n + 1) text.push_back(CH_ZERO + CharWidth'($urandom_range(0, 7)));
         end
         default: text.push_back(CH_ZERO);
      endcase
      // sometimes trailing bytes after the digit run, now and then a terminator among them
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3))
            text.push_back($urandom_range(0, 3) == 0 ?
                           CH_NUL : CharWidth'($urandom_range(0, 255)));
      end
   endtask

   // result side: random stalls plus one long hold-off to back up the input
   initial begin
      int stall;
      bit pressure_done;
      rsp_tready = 0;
      pressure_done = 0;
      rsp_burst = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_burst);
         if (!pressure_done && checker_h.results_seen >= 25) begin
            stall = 600;
            holding_off = 1;
            pressure_done = 1;
         end
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         holding_off = 0;
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         checker_h.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      checker_h = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      chars_sent = 0;
      req_burst = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      req_gap = draw_gap(req_burst);

      // directed: each mode, prefixes without digits, bad first bytes
      send_str("0");
      text = '{CH_NUL};
      send_text();
      send_str("-");
      send_str("0x");
      send_str("0X");
      send_str("09");
      send_str("+1");
      send_str("-9");
      send_str("0xaF");
      send_str("07");
      // embedded terminator hides the rest of the string
      text = '{CH_ONE, CH_NUL, 8'h35};
      send_text();
      text = '{8'hff};
      send_text();
      send_str("9z");

      while (chars_sent < 950) begin
         make_random_text();
         send_text();
      end
      if (req_gap == 0) req_tvalid <= 0;

      while (checker_h.expected_values.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (checker_h.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> int128_literal_parser.f
design/ilp_pkg.sv
design/ilp_core.sv
design/ilp_sign.sv
design/int128_literal_parser.sv
design/ilp_checker.sv
sim/int128_literal_parser_tb.sv
